@@ src/assert_macros.svh @@
// Assertion macros for the SHA-256 RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ src/sha256_pkg.sv @@
// Types, constants and round functions of the SHA-256 engine
`timescale 1ns / 1ps

package sha256_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       last_byte;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } sha_state_t;

  typedef struct packed {
    logic init;
    logic load;
    logic step;
    logic fold;
  } rnd_ctl_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_RND = 6'd63;
  localparam logic [5:0] LEN_FIRST_POS = 6'd56;
  localparam logic [2:0] LAST_IDX = 3'd7;
  localparam logic [63:0] BYTE_BITS = 64'd8;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0][31:0] H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] ch_f(input logic [31:0] e, input logic [31:0] f,
                                       input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] maj_f(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

@@ src/sha256_hash.sv @@
// SHA-256 engine top level: byte intake, padding sequencer and digest output
// One byte per cycle is taken while idle; a full 64-byte block then runs 64 rounds
// and one fold (the load overlaps the last byte).
// Message end: padding runs one byte per cycle up to the block end, then one or two
// compressions, then eight digest words, one per accepted output cycle.
// Reset (rst_n low, synchronous) restores the initial hash and clears all counters.
`timescale 1ns / 1ps

module sha256_hash
  import sha256_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sha_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sha_out_t out_data
);

`include "assert_macros.svh"

  sha_state_t       state_r, state_nxt;
  logic [5:0]       fill_r;
  logic [63:0]      bit_cnt_r;
  logic [5:0]       rnd_cnt_r;
  logic [2:0]       out_idx_r;
  logic             pend_last_r;
  logic             pad_first_r;
  logic             len_phase_r;
  logic             final_r;

  logic             in_fire;
  logic             out_fire;
  logic             byte_we;
  logic [7:0]       byte_val;
  logic [7:0]       pad_byte;
  rnd_ctl_t         rctl;
  logic [31:0]      w_t;
  logic [7:0][31:0] hash;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    if (pad_first_r) begin
      pad_byte = PAD_MARK;
    end else if (len_phase_r && (fill_r >= LEN_FIRST_POS)) begin
      pad_byte = bit_cnt_r[{~fill_r[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.byte_valid && (fill_r == LAST_POS)) begin
            state_nxt = ST_COMP;
          end else if (in_data.last_byte) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill_r == LAST_POS) begin
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        if (rnd_cnt_r == LAST_RND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        priority if (final_r) begin
          state_nxt = ST_OUT;
        end else if (pend_last_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_ready && (out_idx_r == LAST_IDX)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
    byte_we   = ((state_r == ST_IDLE) && in_fire && in_data.byte_valid)
                || (state_r == ST_PAD);
    byte_val  = (state_r == ST_PAD) ? pad_byte : in_data.msg_byte;
    rctl.load = byte_we && (fill_r == LAST_POS);
    rctl.step = (state_r == ST_COMP);
    rctl.fold = (state_r == ST_FOLD);
    rctl.init = out_fire && (out_idx_r == LAST_IDX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      bit_cnt_r   <= '0;
      rnd_cnt_r   <= '0;
      out_idx_r   <= '0;
      pend_last_r <= 1'b0;
      pad_first_r <= 1'b0;
      len_phase_r <= 1'b0;
      final_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (byte_we) begin
        fill_r <= fill_r + 6'd1;
      end
      if (rctl.step) begin
        rnd_cnt_r <= rnd_cnt_r + 6'd1;
      end
      if (out_fire) begin
        out_idx_r <= out_idx_r + 3'd1;
      end
      if ((state_r == ST_IDLE) && in_fire) begin
        pend_last_r <= in_data.last_byte;
        pad_first_r <= in_data.last_byte;
        if (in_data.byte_valid) begin
          bit_cnt_r <= bit_cnt_r + BYTE_BITS;
        end
      end
      if (state_r == ST_PAD) begin
        pend_last_r <= 1'b1;
        pad_first_r <= 1'b0;
        if (pad_first_r && (fill_r < LEN_FIRST_POS)) begin
          len_phase_r <= 1'b1;
        end
        if (fill_r == LAST_POS) begin
          final_r <= len_phase_r;
        end
      end
      if ((state_r == ST_FOLD) && !final_r && pend_last_r && !pad_first_r) begin
        len_phase_r <= 1'b1;
      end
      if (rctl.init) begin
        bit_cnt_r   <= '0;
        len_phase_r <= 1'b0;
        final_r     <= 1'b0;
        pend_last_r <= 1'b0;
      end
    end
  end

  sha256_sched u_sched (
    .clk      (clk),
    .byte_we  (byte_we),
    .byte_in  (byte_val),
    .byte_pos (fill_r[1:0]),
    .step     (rctl.step),
    .w_t      (w_t)
  );

  sha256_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rctl),
    .w_t   (w_t),
    .k_t   (K_TAB[rnd_cnt_r]),
    .hash  (hash)
  );

  assign out_data.digest_word = hash[out_idx_r];
  assign out_data.word_index  = out_idx_r;
  assign out_data.last_word   = (out_idx_r == LAST_IDX);

  `ASSERT_ALWAYS(a_ready_xor_out, !(in_ready && out_valid))
  `ASSERT_IMPL(a_comp_block_aligned, state_r == ST_COMP, fill_r == 6'd0)
  `ASSERT_IMPL(a_fold_after_rounds, state_r == ST_FOLD, rnd_cnt_r == 6'd0)
  `ASSERT_NEXT(a_clear_after_digest, rctl.init, (state_r == ST_IDLE) && (bit_cnt_r == 64'd0))

endmodule

@@ src/sha256_sched.sv @@
// Message schedule: byte-to-word packing and the 16-word rolling schedule line
`timescale 1ns / 1ps

module sha256_sched
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        byte_we,
  input  logic [7:0]  byte_in,
  input  logic [1:0]  byte_pos,
  input  logic        step,
  output logic [31:0] w_t
);

  logic [23:0]       acc_r;
  logic [15:0][31:0] w_r;
  logic [31:0]       word_full;
  logic [31:0]       w_new;

  assign word_full = {acc_r, byte_in};
  assign w_new = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];
  assign w_t = w_r[0];

  always_ff @(posedge clk) begin
    if (byte_we) begin
      acc_r <= word_full[23:0];
    end
    if (step) begin
      w_r <= {w_new, w_r[15:1]};
    end else if (byte_we && (byte_pos == 2'b11)) begin
      w_r <= {word_full, w_r[15:1]};
    end
  end

endmodule

@@ src/sha256_round.sv @@
// Compression round unit: working variables and hash state
`timescale 1ns / 1ps

module sha256_round
  import sha256_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  rnd_ctl_t          ctl,
  input  logic [31:0]       w_t,
  input  logic [31:0]       k_t,
  output logic [7:0][31:0]  hash
);

  logic [7:0][31:0] v_r;
  logic [7:0][31:0] hash_r;
  logic [31:0]      t1;
  logic [31:0]      t2;

  assign t1 = v_r[7] + bsig1(v_r[4]) + ch_f(v_r[4], v_r[5], v_r[6]) + k_t + w_t;
  assign t2 = bsig0(v_r[0]) + maj_f(v_r[0], v_r[1], v_r[2]);
  assign hash = hash_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      v_r <= hash_r;
    end else if (ctl.step) begin
      v_r <= {v_r[6], v_r[5], v_r[4], v_r[3] + t1, v_r[2], v_r[1], v_r[0], t1 + t2};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init) begin
      hash_r <= H_INIT;
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= hash_r[i] + v_r[i];
      end
    end
  end

endmodule

@@ bench/sha256_check_pkg.sv @@
// Digest predictor and result checker for the SHA-256 engine testbench
`timescale 1ns / 1ps

package sha256_check_pkg;
  import sha256_pkg::*;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  class digest_tracker;
    logic [31:0] blk [16];
    logic [31:0] hv [8];
    logic [63:0] bit_total;
    logic [5:0]  fill;
    sha_out_t    pending_q [$];
    int          errors;
    int          words_checked;
    int          messages_closed;

    function new();
      errors = 0;
      words_checked = 0;
      messages_closed = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 16; i++) blk[i] = '0;
      for (int i = 0; i < 8; i++) hv[i] = START_HASH[i];
      bit_total = '0;
      fill = '0;
    endfunction

    function int pending_words();
      return pending_q.size();
    endfunction

    function void put_byte(input logic [5:0] pos, input logic [7:0] b);
      blk[pos[5:2]][8 * (3 - pos[1:0]) +: 8] = b;
    endfunction

    function void fold_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++)
        w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
             + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
      e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
      for (int i = 0; i < 64; i++) begin
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[i] + w[i];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
      hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
    endfunction

    function void take_item(input sha_in_t d);
      int pos;
      if (d.byte_valid) begin
        put_byte(fill, d.msg_byte);
        bit_total += 64'd8;
        fill += 6'd1;
        if (fill == 6'd0) fold_block();
      end
      if (!d.last_byte) return;
      pos = int'(fill);
      put_byte(6'(pos), PAD_BYTE);
      pos++;
      if (pos > 56) begin
        for (; pos < 64; pos++) put_byte(6'(pos), 8'h00);
        fold_block();
        pos = 0;
      end
      for (; pos < 56; pos++) put_byte(6'(pos), 8'h00);
      blk[14] = bit_total[63:32];
      blk[15] = bit_total[31:0];
      fold_block();
      for (int k = 0; k < 8; k++)
        pending_q.push_back(sha_out_t'{digest_word: hv[k], word_index: 3'(k),
                                       last_word: (k == 7)});
      messages_closed++;
      restart();
    endfunction

    function void compare_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
    endfunction

    function void match_word(input sha_out_t got);
      sha_out_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: digest word with nothing expected, expected none, got %h idx %0d last %0b",
                 $time, got.digest_word, got.word_index, got.last_word);
        return;
      end
      want = pending_q.pop_front();
      words_checked++;
      compare_field("digest_word", want.digest_word, got.digest_word);
      compare_field("word_index", 32'(want.word_index), 32'(got.word_index));
      compare_field("last_word", 32'(want.last_word), 32'(got.last_word));
    endfunction
  endclass

endpackage

@@ bench/tb.sv @@
// Top-level testbench for sha256_hash: directed and random messages under handshake gaps
`timescale 1ns / 1ps

module tb;
  import sha256_pkg::*;
  import sha256_check_pkg::*;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  sha_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sha_out_t out_data;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int main_items = 0;
  int noise_items = 0;
  digest_tracker trk;

  sha256_hash DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("sha256_hash test failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) trk.take_item(in_data);
    if (rst_n && out_valid && out_ready) trk.match_word(out_data);
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_item(input logic [7:0] b, input logic v, input logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{msg_byte: b, byte_valid: v, last_byte: l};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (trk.pending_words() != 0) @(posedge clk);
  endtask

  task automatic send_message(input int len);
    logic close_on_byte;
    close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        noise_items++;
      end
      send_item(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (i == len - 1));
      main_items++;
    end
    if (!close_on_byte) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      main_items++;
    end
  endtask

  initial begin
    int boundary_len [6] = '{55, 56, 57, 63, 64, 65};
    int pick;
    int len;
    trk = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(8'ha5, 1'b0, 1'b1);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7f, 1'b1, 1'b1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 81; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 81; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      main_items = 0;
      while (main_items < 32) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) len = $urandom_range(0, 12);
        else if (pick < 8) len = boundary_len[$urandom_range(0, 5)];
        else len = $urandom_range(0, 70);
        send_message(len);
        if ($urandom_range(0, 3) == 0) drain();
      end
      drain();
    end

    repeat (200) @(posedge clk);
    $display("Run covered %0d messages (empty, single-byte and block-boundary lengths),",
             trk.messages_closed);
    $display("%0d digest words compared, %0d ignored empty items, four idle/stall mixes",
             trk.words_checked, noise_items);
    if (trk.errors == 0) begin
      $display("sha256_hash test passed");
    end else begin
      $display("sha256_hash test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/sha256_pkg.sv
src/sha256_sched.sv
src/sha256_round.sv
src/sha256_hash.sv
bench/sha256_check_pkg.sv
bench/tb.sv
